@@ rtl/ptb_pkg.sv @@
package ptb_pkg;

  localparam int unsigned TIMERS    = 16;
  localparam int unsigned ID_BITS   = 4;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned WAIT_BITS = 32;
  localparam int unsigned MARGIN_BITS = 8;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd2;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_REM  = 2'd1,
    ACT_SET  = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0,
    KIND_SUM   = 2'd1,
    KIND_ACK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM
  } state_t;

  // classified command handed from front to back
  typedef struct packed {
    action_t              act;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] period;
    logic                 run;
  } cmd_t;

  // a is at or before b, modulo 2^TIME_BITS
  function automatic logic time_le(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d == '0) || d[TIME_BITS-1];
  endfunction

endpackage

@@ rtl/ptb_front.sv @@
module ptb_front
  import ptb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [ID_BITS-1:0]        timer_id,
  input  logic [TIME_BITS-1:0]      period,
  input  logic                      run,
  output logic                      q_valid,
  input  logic                      q_ready,
  output ptb_pkg::cmd_t             q_cmd
);

  cmd_t       mem [QUEUE_DEPTH];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'(QUEUE_DEPTH));
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{act: action_t'(action), id: timer_id, period: period, run: run};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(QUEUE_DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1)) else $error("count slip");

endmodule

@@ rtl/ptb_back.sv @@
module ptb_back
  import ptb_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  ptb_pkg::cmd_t                q_cmd,
  input  logic [ptb_pkg::MARGIN_BITS-1:0] margin,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [ptb_pkg::ID_BITS-1:0]  fired_id,
  output logic [ptb_pkg::ID_BITS-1:0]  next_id,
  output logic [ptb_pkg::WAIT_BITS-1:0] wait_ms,
  output logic                         any_timers,
  output logic                         status,
  output logic                         last
);

  logic [TIMERS-1:0]    slot_valid, slot_running;
  logic [TIME_BITS-1:0] slot_period [TIMERS];
  logic [TIME_BITS-1:0] slot_due [TIMERS];
  logic [TIME_BITS-1:0] now_ms, now_ms_next;

  state_t state, state_next;
  logic [ID_BITS-1:0]   idx;
  logic [TIME_BITS-1:0] limit;
  logic                 found;
  logic [ID_BITS-1:0]   best;
  logic [TIME_BITS-1:0] best_due;

  logic out_free;
  logic take;
  logic [TIME_BITS-1:0] cur_due, new_due;
  logic [TIME_BITS-1:0] diff_best;
  logic hit;
  logic [TIMERS-1:0] valid_after;
  logic [TIME_BITS-1:0] wait_calc;

  assign out_free = !out_valid || out_ready;
  assign take     = (state == ST_IDLE) && q_valid && out_free;
  assign q_ready  = take;
  assign now_ms_next = now_ms + TIME_BITS'(1);

  assign cur_due = slot_due[idx];
  assign hit     = slot_valid[idx] && time_le(cur_due, limit);
  assign new_due = (hit && slot_running[idx]) ? cur_due + slot_period[idx] : cur_due;

  // new due strictly before the best so far when the difference is negative
  assign diff_best = new_due - best_due;

  // valid set after a command
  always_comb begin
    valid_after = slot_valid;
    if (q_cmd.act == ACT_ADD) valid_after[q_cmd.id] = 1'b1;
    else if (q_cmd.act == ACT_REM) valid_after[q_cmd.id] = 1'b0;
  end

  assign wait_calc = time_le(best_due, now_ms) ? '0 : best_due - now_ms;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take && q_cmd.act == ACT_TICK) state_next = ST_SCAN;
      ST_SCAN: if (out_free && idx == ID_BITS'(TIMERS - 1)) state_next = ST_SUM;
      ST_SUM:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // slot table and clock
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      slot_running <= '0;
      now_ms       <= '0;
    end else if (take) begin
      case (q_cmd.act)
        ACT_ADD: begin
          slot_valid[q_cmd.id]   <= 1'b1;
          slot_running[q_cmd.id] <= q_cmd.run;
        end
        ACT_REM: begin
          slot_valid[q_cmd.id]   <= 1'b0;
          slot_running[q_cmd.id] <= 1'b0;
        end
        ACT_SET: if (slot_valid[q_cmd.id]) slot_running[q_cmd.id] <= q_cmd.run;
        ACT_TICK: now_ms <= now_ms_next;
        default: ;
      endcase
    end
  end

  // payload of the slot table
  always_ff @(posedge clk) begin
    if (take && q_cmd.act == ACT_ADD) begin
      slot_period[q_cmd.id] <= q_cmd.period;
      slot_due[q_cmd.id]    <= now_ms + q_cmd.period;
    end else if (state == ST_SCAN && out_free) begin
      slot_due[idx] <= new_due;
    end
  end

  // scan counter and earliest search
  always_ff @(posedge clk) begin
    if (take) begin
      idx   <= '0;
      limit <= now_ms_next + TIME_BITS'(margin);
      found <= 1'b0;
      best  <= '0;
    end else if (state == ST_SCAN && out_free) begin
      idx <= idx + ID_BITS'(1);
      if (slot_valid[idx] && (!found || diff_best[TIME_BITS-1])) begin
        found    <= 1'b1;
        best     <= idx;
        best_due <= new_due;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && q_cmd.act != ACT_TICK) begin
      out_valid <= 1'b1;
    end else if (state == ST_SCAN && out_free) begin
      out_valid <= hit;
    end else if (state == ST_SUM && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_cmd.act != ACT_TICK) begin
      kind       <= KIND_ACK;
      fired_id   <= '0;
      next_id    <= '0;
      wait_ms    <= '0;
      any_timers <= |valid_after;
      status     <= (q_cmd.act != ACT_ADD) && !slot_valid[q_cmd.id];
      last       <= 1'b1;
    end else if (state == ST_SCAN && out_free) begin
      kind       <= KIND_FIRED;
      fired_id   <= idx;
      next_id    <= '0;
      wait_ms    <= '0;
      any_timers <= |slot_valid;
      status     <= 1'b0;
      last       <= 1'b0;
    end else if (state == ST_SUM && out_free) begin
      kind       <= KIND_SUM;
      fired_id   <= '0;
      next_id    <= best;
      wait_ms    <= found ? wait_calc : '0;
      any_timers <= |slot_valid;
      status     <= 1'b0;
      last       <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    q_ready |-> (state == ST_IDLE)) else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && out_free) |=> (out_valid && last)) else $error("summary lost");

endmodule

@@ rtl/periodic_timer_bank_top.sv @@
// channel  | handshake              | payload
// cfg      | cfg_valid / cfg_ready  | cfg_data (early_margin)
// in       | in_valid / in_ready    | action, timer_id, period, run
// out      | out_valid / out_ready  | kind, fired_id, next_id, wait_ms, any_timers, status, last
//
// add, remove and set each give one acknowledge.
// a tick steps through every slot in the scan unit, firing each due slot, then gives the summary.
// a two-entry command queue decouples the input from the scan engine.
// output stalls hold the scan in place; rst is synchronous and clears all slots.
module periodic_timer_bank_top
  import ptb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptb_pkg::MARGIN_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [ptb_pkg::ID_BITS-1:0]   timer_id,
  input  logic [ptb_pkg::TIME_BITS-1:0] period,
  input  logic                          run,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [ptb_pkg::ID_BITS-1:0]   fired_id,
  output logic [ptb_pkg::ID_BITS-1:0]   next_id,
  output logic [ptb_pkg::WAIT_BITS-1:0] wait_ms,
  output logic                          any_timers,
  output logic                          status,
  output logic                          last
);

  logic [MARGIN_BITS-1:0] early_margin;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  // margin register
  always_ff @(posedge clk) begin
    if (rst) early_margin <= MARGIN_RESET;
    else if (cfg_valid) early_margin <= cfg_data;
  end

  ptb_front u_front (
    .clk, .rst, .in_valid, .in_ready, .action, .timer_id, .period, .run,
    .q_valid, .q_ready, .q_cmd
  );

  ptb_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .margin(early_margin),
    .out_valid, .out_ready, .kind, .fired_id, .next_id, .wait_ms,
    .any_timers, .status, .last
  );

endmodule
